[hdl/rgbhist_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhist_pkg
// Shared types, command codes and constants of the RGB histogram block.
// ----------------------------------------------------------------------------
package rgbhist_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;
  localparam int DIST_BITS      = 25;
  localparam int BIN_ADDR_BITS  = 8;
  localparam int ROW_IDX_BITS   = 6;
  localparam int ROW_BITS       = 1 << ROW_IDX_BITS;
  localparam int ROW_ADDR_BITS  = 24 - ROW_IDX_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = DIST_BITS'(1 << 24);

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] FMT_RGB  = 2'd0;
  localparam logic [1:0] FMT_GRAY = 2'd1;
  localparam logic [1:0] FMT_PAL  = 2'd2;
  localparam logic [1:0] FMT_RSVD = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] first_value;
    logic [7:0] second_value;
    logic [7:0] third_value;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]  red_bin_count;
    logic [OUT_BITS-1:0]  green_bin_count;
    logic [OUT_BITS-1:0]  blue_bin_count;
    logic [OUT_BITS-1:0]  red_peak_count;
    logic [OUT_BITS-1:0]  green_peak_count;
    logic [OUT_BITS-1:0]  blue_peak_count;
    logic [DIST_BITS-1:0] distinct_colors;
    logic                 new_color;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic pal_rd;
    logic bin_rd;
    logic upd;
    logic pal_wr;
    logic clr_start;
    logic clr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic fmt_pal;
  } dp_stat_t;

endpackage

[hdl/rgb_histogram_unique_color_counter.sv]
// ----------------------------------------------------------------------------
// rgb_histogram_unique_color_counter
// RGB channel histograms, running peaks and distinct color count.
// ----------------------------------------------------------------------------
// Usage: transactions arrive on in_valid/in_ready with an in_item_t payload
// (pixel, load palette entry, read bins, clear). Each gives one out_item_t
// on out_valid/out_ready. cfg_we/cfg_data set the pixel format while idle;
// the user must keep to that, as the block itself does not enforce it. A
// pixel steps through palette read (palette format only), bin and bitmap
// read, update and result load; a read bins takes the same steps without
// the palette read, and a palette load goes through palette write and
// result load. Each memory step is one registered access of the palette,
// bin or bitmap memory. The next transaction is accepted the cycle after
// the result is loaded, so a waiting result does not stop intake, but a
// second one waits for the first to be taken.
// The bitmap is 2^18 rows of 64 bits. At reset, and on a clear command,
// a sweep clears one row per cycle (and the bin memories alongside), with
// in_ready low. A clear returns an all-zero result after the sweep. When
// the receiver stalls, the result holds.
// ----------------------------------------------------------------------------
module rgb_histogram_unique_color_counter #(
  parameter int COUNT_BITS = rgbhist_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rgbhist_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rgbhist_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_data
);

  rgbhist_pkg::dp_cmd_t  dp_cmd;
  rgbhist_pkg::dp_stat_t dp_stat;
  logic [1:0]            fmt_r;

  // Pixel format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= rgbhist_pkg::FMT_RGB;
    end else if (cfg_we) begin
      fmt_r <= cfg_data;
    end
  end

  rgbhist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  rgbhist_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_fmt  (fmt_r),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_data (out_data)
  );

endmodule

[hdl/rgbhist_ctrl.sv]
// ----------------------------------------------------------------------------
// rgbhist_ctrl
// Sequencer: steps each transaction through palette lookup, bin and bitmap
// read, update and result hand-off; runs the clearing sweep.
// ----------------------------------------------------------------------------
module rgbhist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgbhist_pkg::dp_cmd_t dp_cmd,
  input  rgbhist_pkg::dp_stat_t dp_stat
);

  typedef enum logic [2:0] {
    S_CSTART, S_CLR, S_IDLE, S_PAL, S_RD, S_UPD, S_PWR, S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   from_cmd_r, from_cmd_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Decode datapath commands from state
  always_comb begin
    dp_cmd           = '0;
    dp_cmd.cap       = accept;
    dp_cmd.clr_start = (state_r == S_CSTART);
    dp_cmd.clr       = (state_r == S_CLR);
    dp_cmd.pal_rd    = (state_r == S_PAL);
    dp_cmd.bin_rd    = (state_r == S_RD);
    dp_cmd.upd       = (state_r == S_UPD);
    dp_cmd.pal_wr    = (state_r == S_PWR);
    dp_cmd.out_load  = (state_r == S_SEND) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt    = state_r;
    from_cmd_nxt = from_cmd_r;
    case (state_r)
      S_CSTART: state_nxt = S_CLR;
      S_CLR: begin
        if (dp_stat.clr_done) begin
          state_nxt = from_cmd_r ? S_SEND : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            rgbhist_pkg::CMD_PIXEL: state_nxt = dp_stat.fmt_pal ? S_PAL : S_RD;
            rgbhist_pkg::CMD_LOAD:  state_nxt = S_PWR;
            rgbhist_pkg::CMD_READ:  state_nxt = S_RD;
            default: begin
              state_nxt    = S_CSTART;
              from_cmd_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PAL:  state_nxt = S_RD;
      S_RD:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_SEND;
      S_PWR:  state_nxt = S_SEND;
      S_SEND: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CSTART;
      from_cmd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_cmd_r  <= (state_nxt == S_SEND) ? 1'b0 : from_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No transaction is taken while the sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.clr |-> !in_ready)
    else $error("input accepted during clearing sweep");

  // One transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transaction accepted while busy");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !dp_cmd.out_load)
    else $error("result overwritten while stalled");

  // A result appears only after a load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !dp_cmd.out_load) |=> !out_valid_r)
    else $error("result valid without load");

endmodule

[hdl/rgbhist_dp.sv]
// ----------------------------------------------------------------------------
// rgbhist_dp
// Datapath: palette, three bin memories, presence bitmap, peaks, distinct
// count and the result register.
// ----------------------------------------------------------------------------
module rgbhist_dp #(
  parameter int COUNT_BITS = rgbhist_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rgbhist_pkg::in_item_t  in_data,
  input  logic [1:0]             cfg_fmt,
  input  rgbhist_pkg::dp_cmd_t   dp_cmd,
  output rgbhist_pkg::dp_stat_t  dp_stat,
  output rgbhist_pkg::out_item_t out_data
);

  localparam int RAB = rgbhist_pkg::ROW_ADDR_BITS;
  localparam int RB  = rgbhist_pkg::ROW_BITS;
  localparam int DB  = rgbhist_pkg::DIST_BITS;
  localparam int OB  = rgbhist_pkg::OUT_BITS;

  rgbhist_pkg::in_item_t  item_r;
  rgbhist_pkg::out_item_t res_r, out_r;

  logic [23:0]           pal_mem [256];
  logic [23:0]           pal_q_r;
  logic [COUNT_BITS-1:0] red_mem [256];
  logic [COUNT_BITS-1:0] grn_mem [256];
  logic [COUNT_BITS-1:0] blu_mem [256];
  logic [COUNT_BITS-1:0] red_q_r, grn_q_r, blu_q_r;
  logic [RB-1:0]         seen_mem [1 << RAB];
  logic [RB-1:0]         row_q_r;

  logic [COUNT_BITS-1:0] red_pk_r, grn_pk_r, blu_pk_r;
  logic [COUNT_BITS-1:0] red_pk_nxt, grn_pk_nxt, blu_pk_nxt;
  logic [COUNT_BITS-1:0] red_inc, grn_inc, blu_inc;
  logic [DB-1:0]         dist_r, dist_nxt;
  logic [RAB-1:0]        clr_cnt_r;

  logic [23:0]           rgb, addr;
  logic                  is_pixel, seen_bit;
  logic [RAB-1:0]        row_addr;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  assign is_pixel = (item_r.command == rgbhist_pkg::CMD_PIXEL);
  assign dp_stat.clr_done = &clr_cnt_r;
  assign dp_stat.fmt_pal  = (cfg_fmt == rgbhist_pkg::FMT_PAL);
  assign out_data = out_r;

  // Turn the pixel into an RGB triple
  always_comb begin
    case (cfg_fmt)
      rgbhist_pkg::FMT_GRAY:
        rgb = {item_r.first_value, item_r.first_value, item_r.first_value};
      rgbhist_pkg::FMT_PAL: rgb = pal_q_r;
      default: rgb = {item_r.first_value, item_r.second_value, item_r.third_value};
    endcase
    addr = is_pixel ? rgb
                    : {item_r.first_value, item_r.second_value, item_r.third_value};
  end

  assign row_addr = addr[23 -: RAB];
  assign seen_bit = row_q_r[addr[rgbhist_pkg::ROW_IDX_BITS-1:0]];

  // Saturating bin increments and running peaks
  always_comb begin
    red_inc    = sat_inc(red_q_r);
    grn_inc    = sat_inc(grn_q_r);
    blu_inc    = sat_inc(blu_q_r);
    red_pk_nxt = (red_inc > red_pk_r) ? red_inc : red_pk_r;
    grn_pk_nxt = (grn_inc > grn_pk_r) ? grn_inc : grn_pk_r;
    blu_pk_nxt = (blu_inc > blu_pk_r) ? blu_inc : blu_pk_r;
    dist_nxt   = (!seen_bit && dist_r < rgbhist_pkg::DIST_MAX) ? dist_r + DB'(1) : dist_r;
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (dp_cmd.cap) begin
      item_r <= in_data;
    end
  end

  // Palette memory
  always_ff @(posedge clk) begin
    if (dp_cmd.pal_wr) begin
      pal_mem[item_r.entry_index] <=
        {item_r.first_value, item_r.second_value, item_r.third_value};
    end
    if (dp_cmd.pal_rd) begin
      pal_q_r <= pal_mem[item_r.first_value];
    end
  end

  // Bin memories: sweep clear or pixel write, registered read
  always_ff @(posedge clk) begin
    if (dp_cmd.clr) begin
      red_mem[clr_cnt_r[7:0]] <= '0;
      grn_mem[clr_cnt_r[7:0]] <= '0;
      blu_mem[clr_cnt_r[7:0]] <= '0;
    end else if (dp_cmd.upd && is_pixel) begin
      red_mem[addr[23:16]] <= red_inc;
      grn_mem[addr[15:8]]  <= grn_inc;
      blu_mem[addr[7:0]]   <= blu_inc;
    end
    if (dp_cmd.bin_rd) begin
      red_q_r <= red_mem[addr[23:16]];
      grn_q_r <= grn_mem[addr[15:8]];
      blu_q_r <= blu_mem[addr[7:0]];
    end
  end

  // Presence bitmap, one row per cycle during the sweep
  always_ff @(posedge clk) begin
    if (dp_cmd.clr) begin
      seen_mem[clr_cnt_r] <= '0;
    end else if (dp_cmd.upd && is_pixel && !seen_bit) begin
      seen_mem[row_addr] <= row_q_r | (RB'(1) << addr[rgbhist_pkg::ROW_IDX_BITS-1:0]);
    end
    if (dp_cmd.bin_rd) begin
      row_q_r <= seen_mem[row_addr];
    end
  end

  // Sweep counter, peaks and distinct count
  always_ff @(posedge clk) begin
    if (!rst_n || dp_cmd.clr_start) begin
      clr_cnt_r <= '0;
      red_pk_r  <= '0;
      grn_pk_r  <= '0;
      blu_pk_r  <= '0;
      dist_r    <= '0;
    end else begin
      if (dp_cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + RAB'(1);
      end
      if (dp_cmd.upd && is_pixel) begin
        red_pk_r <= red_pk_nxt;
        grn_pk_r <= grn_pk_nxt;
        blu_pk_r <= blu_pk_nxt;
        dist_r   <= dist_nxt;
      end
    end
  end

  // Assemble the result
  always_ff @(posedge clk) begin
    if (dp_cmd.clr_start) begin
      res_r <= '0;
    end else if (dp_cmd.upd) begin
      res_r.distinct_colors <= is_pixel ? dist_nxt : dist_r;
      res_r.new_color       <= is_pixel && !seen_bit;
      if (is_pixel) begin
        res_r.red_bin_count    <= OB'(red_inc);
        res_r.green_bin_count  <= OB'(grn_inc);
        res_r.blue_bin_count   <= OB'(blu_inc);
        res_r.red_peak_count   <= OB'(red_pk_nxt);
        res_r.green_peak_count <= OB'(grn_pk_nxt);
        res_r.blue_peak_count  <= OB'(blu_pk_nxt);
      end else begin
        res_r.red_bin_count    <= OB'(red_q_r);
        res_r.green_bin_count  <= OB'(grn_q_r);
        res_r.blue_bin_count   <= OB'(blu_q_r);
        res_r.red_peak_count   <= OB'(red_pk_r);
        res_r.green_peak_count <= OB'(grn_pk_r);
        res_r.blue_peak_count  <= OB'(blu_pk_r);
      end
    end else if (dp_cmd.pal_wr) begin
      res_r.red_bin_count    <= '0;
      res_r.green_bin_count  <= '0;
      res_r.blue_bin_count   <= '0;
      res_r.red_peak_count   <= OB'(red_pk_r);
      res_r.green_peak_count <= OB'(grn_pk_r);
      res_r.blue_peak_count  <= OB'(blu_pk_r);
      res_r.distinct_colors  <= dist_r;
      res_r.new_color        <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      out_r <= res_r;
    end
  end

endmodule

[test/rgbhist_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhist_checker
// Watches both channels of the histogram block, predicts every result from
// its own copy of the bins, peaks, palette and color bitmap, and compares.
// ----------------------------------------------------------------------------
module rgbhist_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  rgbhist_pkg::in_item_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  rgbhist_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_data,
  output int                     err_count,
  output int                     pending
);

  localparam logic [31:0] BIN_MAX = 32'hFFFF_FFFF;

  logic [31:0]                       red_hist [256];
  logic [31:0]                       green_hist [256];
  logic [31:0]                       blue_hist [256];
  logic [31:0]                       red_top, green_top, blue_top;
  logic [23:0]                       pal_mem [256];
  bit                                color_seen [int];
  logic [rgbhist_pkg::DIST_BITS-1:0] color_total;
  logic [1:0]                        fmt;
  rgbhist_pkg::out_item_t            expected_q[$];

  initial begin
    err_count = 0;
    fmt = rgbhist_pkg::FMT_RGB;
    wipe_stats();
  end

  assign pending = expected_q.size();

  function automatic void wipe_stats();
    for (int i = 0; i < 256; i++) begin
      red_hist[i] = '0;
      green_hist[i] = '0;
      blue_hist[i] = '0;
    end
    red_top = '0;
    green_top = '0;
    blue_top = '0;
    color_seen.delete();
    color_total = '0;
  endfunction

  // Saturating bin increment that drags the channel peak along
  function automatic logic [31:0] bump_bin(ref logic [31:0] hist [256],
                                           input logic [7:0] idx,
                                           ref logic [31:0] top);
    logic [31:0] v;
    v = hist[idx];
    if (v != BIN_MAX) v = v + 1;
    hist[idx] = v;
    if (v > top) top = v;
    return v;
  endfunction

  function automatic rgbhist_pkg::out_item_t predict_stats(rgbhist_pkg::in_item_t it);
    rgbhist_pkg::out_item_t r;
    logic [7:0]             rv, gv, bv;
    int                     key;
    r = '0;
    case (it.command)
      rgbhist_pkg::CMD_PIXEL: begin
        if (fmt == rgbhist_pkg::FMT_GRAY) begin
          rv = it.first_value; gv = it.first_value; bv = it.first_value;
        end else if (fmt == rgbhist_pkg::FMT_PAL) begin
          {rv, gv, bv} = pal_mem[it.first_value];
        end else begin
          rv = it.first_value; gv = it.second_value; bv = it.third_value;
        end
        r.red_bin_count   = bump_bin(red_hist, rv, red_top);
        r.green_bin_count = bump_bin(green_hist, gv, green_top);
        r.blue_bin_count  = bump_bin(blue_hist, bv, blue_top);
        key = {8'd0, rv, gv, bv};
        if (!color_seen.exists(key)) begin
          color_seen[key] = 1'b1;
          if (color_total < rgbhist_pkg::DIST_MAX) color_total = color_total + 1;
          r.new_color = 1'b1;
        end
      end
      rgbhist_pkg::CMD_LOAD:
        pal_mem[it.entry_index] = {it.first_value, it.second_value, it.third_value};
      rgbhist_pkg::CMD_READ: begin
        r.red_bin_count   = red_hist[it.first_value];
        r.green_bin_count = green_hist[it.second_value];
        r.blue_bin_count  = blue_hist[it.third_value];
      end
      default: wipe_stats();
    endcase
    if (it.command != rgbhist_pkg::CMD_CLEAR) begin
      r.red_peak_count   = red_top;
      r.green_peak_count = green_top;
      r.blue_peak_count  = blue_top;
      r.distinct_colors  = color_total;
    end
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
  endtask

  // Predict on each accepted input transaction, compare each accepted result
  always @(posedge clk) begin
    rgbhist_pkg::out_item_t w;
    if (rst_n) begin
      if (cfg_we) fmt <= cfg_data;
      if (in_valid && in_ready) expected_q.push_back(predict_stats(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: result with no transaction outstanding", $realtime);
        end else begin
          w = expected_q.pop_front();
          if (out_data.red_bin_count !== w.red_bin_count)
            report("red_bin_count", out_data.red_bin_count, w.red_bin_count);
          if (out_data.green_bin_count !== w.green_bin_count)
            report("green_bin_count", out_data.green_bin_count, w.green_bin_count);
          if (out_data.blue_bin_count !== w.blue_bin_count)
            report("blue_bin_count", out_data.blue_bin_count, w.blue_bin_count);
          if (out_data.red_peak_count !== w.red_peak_count)
            report("red_peak_count", out_data.red_peak_count, w.red_peak_count);
          if (out_data.green_peak_count !== w.green_peak_count)
            report("green_peak_count", out_data.green_peak_count, w.green_peak_count);
          if (out_data.blue_peak_count !== w.blue_peak_count)
            report("blue_peak_count", out_data.blue_peak_count, w.blue_peak_count);
          if (out_data.distinct_colors !== w.distinct_colors)
            report("distinct_colors", 32'(out_data.distinct_colors), 32'(w.distinct_colors));
          if (out_data.new_color !== w.new_color)
            report("new_color", 32'(out_data.new_color), 32'(w.new_color));
        end
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives pixels, palette loads, bin reads and clears into the histogram
// block across all pixel formats and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  rgbhist_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rgbhist_pkg::out_item_t out_data;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_data = '0;
  int                     err_count, pending;
  int                     idle_pct = 0, stall_pct = 0;
  int                     cycles = 0;
  bit                     hold_req = 1'b0;
  int                     hold_left = 0;
  bit                     pal_written [256];
  logic [1:0]             cur_fmt = rgbhist_pkg::FMT_RGB;

  always #5 clk = ~clk;

  rgb_histogram_unique_color_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  rgbhist_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= 300;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(rgbhist_pkg::in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.command == rgbhist_pkg::CMD_LOAD) pal_written[it.entry_index] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_format(logic [1:0] f);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= f;
    cur_fmt  = f;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rgbhist_pkg::in_item_t mk(logic [1:0] c, logic [7:0] a,
                                               logic [7:0] b, logic [7:0] d,
                                               logic [7:0] e);
    rgbhist_pkg::in_item_t it;
    it.command = c; it.first_value = a; it.second_value = b;
    it.third_value = d; it.entry_index = e;
    return it;
  endfunction

  // Narrow pool half of the time so bins grow and colors repeat
  function automatic logic [7:0] pick_level();
    if ($urandom_range(1)) return 8'($urandom_range(3)) ^ ($urandom_range(1) ? 8'hFF : 8'h00);
    return 8'($urandom_range(255));
  endfunction

  function automatic rgbhist_pkg::in_item_t random_item();
    rgbhist_pkg::in_item_t it;
    int                    roll, idx;
    roll = $urandom_range(99);
    it = mk(rgbhist_pkg::CMD_PIXEL, pick_level(), pick_level(), pick_level(),
            8'($urandom_range(255)));
    if (roll >= 85) it.command = rgbhist_pkg::CMD_READ;
    else if (roll >= 70) it.command = rgbhist_pkg::CMD_LOAD;
    if (it.command == rgbhist_pkg::CMD_PIXEL && cur_fmt == rgbhist_pkg::FMT_PAL) begin
      // stay on palette entries that hold a color
      do idx = $urandom_range(255); while (!pal_written[idx]);
      it.first_value = 8'(idx);
    end
    return it;
  endfunction

  initial begin
    logic [1:0] phase_fmt [4];
    int         phase_idle [4];
    int         phase_stall [4];
    phase_fmt = '{rgbhist_pkg::FMT_RGB, rgbhist_pkg::FMT_GRAY, rgbhist_pkg::FMT_PAL,
                  rgbhist_pkg::FMT_RSVD};
    phase_idle = '{0, 51, 0, 27};
    phase_stall = '{0, 0, 51, 27};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, repeats, palette loads, reads, clear
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send(mk(rgbhist_pkg::CMD_LOAD, 8'h12, 8'h34, 8'h56, 8'h00));
    send(mk(rgbhist_pkg::CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(mk(rgbhist_pkg::CMD_LOAD, 8'hAA, 8'h55, 8'h00, 8'hA5));
    send(mk(rgbhist_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h5A));
    send(mk(rgbhist_pkg::CMD_READ, 8'h00, 8'hFF, 8'h00, 8'h00));
    send(mk(rgbhist_pkg::CMD_READ, 8'hFF, 8'h00, 8'hFF, 8'hFF));
    send(mk(rgbhist_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(mk(rgbhist_pkg::CMD_READ, 8'h00, 8'hFF, 8'h00, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00));
    set_format(rgbhist_pkg::FMT_GRAY);
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h00, 8'h11, 8'h22, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00));
    set_format(rgbhist_pkg::FMT_PAL);
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hA5, 8'hFF, 8'hFF, 8'hFF));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h5A, 8'h00, 8'h00, 8'h00));
    set_format(rgbhist_pkg::FMT_RSVD);
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'h01, 8'h02, 8'h03, 8'h00));
    send(mk(rgbhist_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));

    // Random phases, each under its own format and handshake pattern
    for (int p = 0; p < 4; p++) begin
      set_format(phase_fmt[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 3) send(mk(rgbhist_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
      for (int n = 0; n < 132; n++) begin
        // stretches with no idling inside each phase
        if (n % 44 == 30) begin
          idle_pct = 0; stall_pct = 0;
        end else if (n % 44 == 0) begin
          idle_pct = phase_idle[p]; stall_pct = phase_stall[p];
        end
        if (p == 0 && n == 40) hold_req = 1'b1;
        if (p == 0 && n == 41) hold_req = 1'b0;
        send(random_item());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
